// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files of the linked-list table.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLT_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("linked-list table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LLT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("linked-list table assertion failed");

`endif

// ----- design/llt_pkg.sv -----
// Package of the linked-list table: field widths, request and status codes,
// key masks and the index check. Depends on nothing.
package llt_pkg;

  localparam int REQ_W   = 2;
  localparam int IDX_W   = 7;
  localparam int KHI_W   = 56;
  localparam int KLO_W   = 64;
  localparam int STAT_W  = 2;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_KEY_BYTES   = 15;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [KHI_W-1:0]  khi_t;
  typedef logic [KLO_W-1:0]  klo_t;
  typedef logic [KHI_W+KLO_W-1:0] key_t;

  // Request codes.
  localparam req_t REQ_ADD    = 2'd0;
  localparam req_t REQ_DELETE = 2'd1;
  localparam req_t REQ_SEARCH = 2'd2;

  // Result status codes.
  localparam stat_t ST_OK        = 2'd0;
  localparam stat_t ST_NOT_FOUND = 2'd1;
  localparam stat_t ST_FULL      = 2'd2;
  localparam stat_t ST_EMPTY     = 2'd3;

  // Link value that ends a list.
  localparam idx_t NO_ENTRY = 7'h7F;

  // Mask of the key bytes held in the high word; byte 0 sits in the top bits.
  function automatic khi_t hi_mask(int kb);
    khi_t m;
    m = '0;
    for (int j = 0; j < 7; j++) begin
      if (j < kb) m[KHI_W-1-8*j -: 8] = 8'hFF;
    end
    return m;
  endfunction

  // Mask of the key bytes held in the low word; byte 7 sits in the top bits.
  function automatic klo_t lo_mask(int kb);
    klo_t m;
    m = '0;
    for (int j = 0; j < 8; j++) begin
      if (j + 7 < kb) m[KLO_W-1-8*j -: 8] = 8'hFF;
    end
    return m;
  endfunction

  // An index is live when it is non-negative and below the used count.
  function automatic logic idx_valid(idx_t x, idx_t used);
    return !x[IDX_W-1] && (x < used);
  endfunction

endpackage

// ----- design/llt_req_if.sv -----
// Request channel of the linked-list table: valid/ready and one request beat.
// Depends on llt_pkg for the field types.
interface llt_req_if;
  logic             valid;
  logic             ready;
  llt_pkg::req_t    req_type;
  llt_pkg::idx_t    head;
  llt_pkg::khi_t    key_high;
  llt_pkg::klo_t    key_low;

  modport source(output valid, req_type, head, key_high, key_low, input ready);
  modport sink(input valid, req_type, head, key_high, key_low, output ready);
endinterface

// ----- design/llt_rsp_if.sv -----
// Result channel of the linked-list table: valid/ready and one result beat.
// Depends on llt_pkg for the field types.
interface llt_rsp_if;
  logic             valid;
  logic             ready;
  llt_pkg::stat_t   status;
  llt_pkg::idx_t    new_head;
  llt_pkg::idx_t    entry_index;
  llt_pkg::khi_t    out_key_high;
  llt_pkg::klo_t    out_key_low;
  logic             last;

  modport source(output valid, status, new_head, entry_index, out_key_high, out_key_low,
                 last, input ready);
  modport sink(input valid, status, new_head, entry_index, out_key_high, out_key_low,
               last, output ready);
endinterface

// ----- design/linked_list_table_with_free_list_unit.sv -----
// Top level of the linked-list table with free list.
// Depends on llt_pkg, llt_req_if and llt_rsp_if.
//
// Usage: a request beat on in_req (add, delete or search, a list head and a
// key) is taken when in_req.valid and in_req.ready are both high. Ready is
// high only while the sequencer is idle. Add and delete answer with one beat
// on out_rsp; search answers with one beat per list entry, the final beat
// marked by last. Request code 3 is dropped without a result.
// Walk: every list step uses the single table read port, for an address
// step and then a compare or link step. An add that reuses a freed entry
// first pops it off the free list. A walk visits at most TABLE_DEPTH
// entries, and a search gives one beat per entry as the output register
// frees. A full table or a search of an empty list answers with one beat
// and no table read, a delete on an empty list with not-found.
// Reset: the synchronous active-low reset empties the free list, clears the
// used-entry count and the output valid flag; the table itself needs no clear.
// Stalls: results sit in one output register; while the receiver holds ready
// low the walk pauses on the pending result and no beat is lost.
module linked_list_table_with_free_list_unit #(
  parameter int TABLE_DEPTH = llt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = llt_pkg::DEF_KEY_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  llt_req_if.sink   in_req,
  llt_rsp_if.source out_rsp
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam llt_pkg::khi_t HI_MASK = llt_pkg::hi_mask(KEY_BYTES);
  localparam llt_pkg::klo_t LO_MASK = llt_pkg::lo_mask(KEY_BYTES);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_POP_RD   = 4'd1;
  localparam logic [3:0] S_POP_WR   = 4'd2;
  localparam logic [3:0] S_ADD_WR   = 4'd3;
  localparam logic [3:0] S_WALK_RD  = 4'd4;
  localparam logic [3:0] S_WALK_CHK = 4'd5;
  localparam logic [3:0] S_LINK     = 4'd6;
  localparam logic [3:0] S_DEL_FIX  = 4'd7;
  localparam logic [3:0] S_DEL_FREE = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  // Table storage with registered read data.
  llt_pkg::key_t key_mem [TABLE_DEPTH];
  llt_pkg::idx_t next_mem [TABLE_DEPTH];
  llt_pkg::key_t key_rd_r;
  llt_pkg::idx_t next_rd_r;

  logic           rd_en, key_we, next_we;
  logic [IW-1:0]  rd_a, key_wa, next_wa;
  llt_pkg::idx_t  next_wd;

  // Control and request registers.
  logic [3:0]     state_r, state_nxt;
  logic [CW-1:0]  used_r, used_nxt;
  llt_pkg::idx_t  free_head_r, free_head_nxt;
  llt_pkg::req_t  req_r, req_nxt;
  llt_pkg::idx_t  head_r, head_nxt;
  llt_pkg::khi_t  key_hi_r, key_hi_nxt;
  llt_pkg::klo_t  key_lo_r, key_lo_nxt;
  llt_pkg::idx_t  cur_r, cur_nxt;
  llt_pkg::idx_t  prev_r, prev_nxt;
  llt_pkg::idx_t  e_r, e_nxt;
  llt_pkg::idx_t  after_r, after_nxt;
  logic [CW-1:0]  n_r, n_nxt;

  // Pending single result.
  llt_pkg::stat_t p_status_r, p_status_nxt;
  llt_pkg::idx_t  p_head_r, p_head_nxt;
  llt_pkg::idx_t  p_index_r, p_index_nxt;

  // Output register.
  logic           out_valid_r, out_valid_nxt;
  llt_pkg::stat_t out_status_r, out_status_nxt;
  llt_pkg::idx_t  out_head_r, out_head_nxt;
  llt_pkg::idx_t  out_index_r, out_index_nxt;
  llt_pkg::khi_t  out_khi_r, out_khi_nxt;
  llt_pkg::klo_t  out_klo_r, out_klo_nxt;
  logic           out_last_r, out_last_nxt;

  logic           slot_free, load_out, accept;
  logic           in_head_ok, prev_ok, cur_ok, next_ok, key_hit, walk_fin;
  llt_pkg::idx_t  used7;
  llt_pkg::idx_t  in_head_norm;

  assign used7       = llt_pkg::IDX_W'(used_r);
  assign slot_free   = !out_valid_r || out_rsp.ready;
  assign accept      = in_req.valid && in_req.ready;
  assign in_head_ok  = llt_pkg::idx_valid(in_req.head, used7);
  assign in_head_norm = in_head_ok ? in_req.head : llt_pkg::NO_ENTRY;
  assign prev_ok     = llt_pkg::idx_valid(prev_r, used7);
  assign cur_ok      = llt_pkg::idx_valid(cur_r, used7);
  assign next_ok     = llt_pkg::idx_valid(next_rd_r, used7);
  assign key_hit     = (key_rd_r == {key_hi_r, key_lo_r});
  assign walk_fin    = (n_r == CW'(TABLE_DEPTH - 1)) || !next_ok;

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    free_head_nxt = free_head_r;
    req_nxt       = req_r;
    head_nxt      = head_r;
    key_hi_nxt    = key_hi_r;
    key_lo_nxt    = key_lo_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    e_nxt         = e_r;
    after_nxt     = after_r;
    n_nxt         = n_r;
    p_status_nxt  = p_status_r;
    p_head_nxt    = p_head_r;
    p_index_nxt   = p_index_r;

    rd_en   = 1'b0;
    rd_a    = cur_r[IW-1:0];
    key_we  = 1'b0;
    key_wa  = e_r[IW-1:0];
    next_we = 1'b0;
    next_wa = e_r[IW-1:0];
    next_wd = llt_pkg::NO_ENTRY;

    load_out       = 1'b0;
    out_status_nxt = out_status_r;
    out_head_nxt   = out_head_r;
    out_index_nxt  = out_index_r;
    out_khi_nxt    = out_khi_r;
    out_klo_nxt    = out_klo_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt    = in_req.req_type;
          head_nxt   = in_head_norm;
          key_hi_nxt = in_req.key_high & HI_MASK;
          key_lo_nxt = in_req.key_low & LO_MASK;
          cur_nxt    = in_head_norm;
          prev_nxt   = llt_pkg::NO_ENTRY;
          n_nxt      = '0;
          case (in_req.req_type)
            llt_pkg::REQ_ADD: begin
              if (llt_pkg::idx_valid(free_head_r, used7)) begin
                e_nxt     = free_head_r;
                state_nxt = S_POP_RD;
              end else if (used_r < CW'(TABLE_DEPTH)) begin
                e_nxt     = used7;
                used_nxt  = used_r + CW'(1);
                state_nxt = S_ADD_WR;
              end else begin
                p_status_nxt = llt_pkg::ST_FULL;
                p_head_nxt   = in_head_norm;
                p_index_nxt  = llt_pkg::NO_ENTRY;
                state_nxt    = S_EMIT;
              end
            end
            llt_pkg::REQ_DELETE: begin
              state_nxt = S_WALK_RD;
            end
            llt_pkg::REQ_SEARCH: begin
              if (in_head_ok) begin
                state_nxt = S_WALK_RD;
              end else begin
                p_status_nxt = llt_pkg::ST_EMPTY;
                p_head_nxt   = llt_pkg::NO_ENTRY;
                p_index_nxt  = llt_pkg::NO_ENTRY;
                state_nxt    = S_EMIT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Read the link of the free-list head to pop it.
      S_POP_RD: begin
        rd_en     = 1'b1;
        rd_a      = free_head_r[IW-1:0];
        state_nxt = S_POP_WR;
      end

      S_POP_WR: begin
        free_head_nxt = next_ok ? next_rd_r : llt_pkg::NO_ENTRY;
        state_nxt     = S_ADD_WR;
      end

      // Store the new key and terminate the new entry.
      S_ADD_WR: begin
        key_we    = 1'b1;
        next_we   = 1'b1;
        next_wd   = llt_pkg::NO_ENTRY;
        state_nxt = S_WALK_RD;
      end

      // Issue the read of the current entry, or finish the walk.
      S_WALK_RD: begin
        if ((n_r < CW'(TABLE_DEPTH)) && cur_ok) begin
          rd_en     = 1'b1;
          state_nxt = S_WALK_CHK;
        end else begin
          case (req_r)
            llt_pkg::REQ_ADD: begin
              state_nxt = S_LINK;
            end
            llt_pkg::REQ_DELETE: begin
              p_status_nxt = llt_pkg::ST_NOT_FOUND;
              p_head_nxt   = head_r;
              p_index_nxt  = llt_pkg::NO_ENTRY;
              state_nxt    = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Use the entry just read: compare, emit or step to the next link.
      S_WALK_CHK: begin
        case (req_r)
          llt_pkg::REQ_DELETE: begin
            if (key_hit) begin
              after_nxt = next_ok ? next_rd_r : llt_pkg::NO_ENTRY;
              state_nxt = S_DEL_FIX;
            end else begin
              prev_nxt  = cur_r;
              cur_nxt   = next_rd_r;
              n_nxt     = n_r + CW'(1);
              state_nxt = S_WALK_RD;
            end
          end
          llt_pkg::REQ_SEARCH: begin
            if (slot_free) begin
              load_out       = 1'b1;
              out_status_nxt = llt_pkg::ST_OK;
              out_head_nxt   = head_r;
              out_index_nxt  = cur_r;
              out_khi_nxt    = key_rd_r[llt_pkg::KHI_W+llt_pkg::KLO_W-1:llt_pkg::KLO_W];
              out_klo_nxt    = key_rd_r[llt_pkg::KLO_W-1:0];
              out_last_nxt   = walk_fin;
              if (walk_fin) begin
                state_nxt = S_IDLE;
              end else begin
                cur_nxt   = next_rd_r;
                n_nxt     = n_r + CW'(1);
                state_nxt = S_WALK_RD;
              end
            end
          end
          default: begin
            prev_nxt  = cur_r;
            cur_nxt   = next_rd_r;
            n_nxt     = n_r + CW'(1);
            state_nxt = S_WALK_RD;
          end
        endcase
      end

      // Append the new entry after the last entry visited.
      S_LINK: begin
        next_we      = prev_ok;
        next_wa      = prev_r[IW-1:0];
        next_wd      = e_r;
        p_status_nxt = llt_pkg::ST_OK;
        p_head_nxt   = prev_ok ? head_r : e_r;
        p_index_nxt  = e_r;
        state_nxt    = S_EMIT;
      end

      // Bridge the predecessor over the removed entry.
      S_DEL_FIX: begin
        next_we   = prev_ok;
        next_wa   = prev_r[IW-1:0];
        next_wd   = after_r;
        state_nxt = S_DEL_FREE;
      end

      // Push the removed entry onto the free list.
      S_DEL_FREE: begin
        next_we       = 1'b1;
        next_wa       = cur_r[IW-1:0];
        next_wd       = free_head_r;
        free_head_nxt = cur_r;
        p_status_nxt  = llt_pkg::ST_OK;
        p_head_nxt    = prev_ok ? head_r : after_r;
        p_index_nxt   = cur_r;
        state_nxt     = S_EMIT;
      end

      // Hand the single result to the output register.
      S_EMIT: begin
        if (slot_free) begin
          load_out       = 1'b1;
          out_status_nxt = p_status_r;
          out_head_nxt   = p_head_r;
          out_index_nxt  = p_index_r;
          out_khi_nxt    = '0;
          out_klo_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Table memories: one write port each, one shared read address.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= {key_hi_r, key_lo_r};
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (rd_en) begin
      key_rd_r  <= key_mem[rd_a];
      next_rd_r <= next_mem[rd_a];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      free_head_r <= llt_pkg::NO_ENTRY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    head_r       <= head_nxt;
    key_hi_r     <= key_hi_nxt;
    key_lo_r     <= key_lo_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    e_r          <= e_nxt;
    after_r      <= after_nxt;
    n_r          <= n_nxt;
    p_status_r   <= p_status_nxt;
    p_head_r     <= p_head_nxt;
    p_index_r    <= p_index_nxt;
    out_status_r <= out_status_nxt;
    out_head_r   <= out_head_nxt;
    out_index_r  <= out_index_nxt;
    out_khi_r    <= out_khi_nxt;
    out_klo_r    <= out_klo_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.new_head     = out_head_r;
  assign out_rsp.entry_index  = out_index_r;
  assign out_rsp.out_key_high = out_khi_r;
  assign out_rsp.out_key_low  = out_klo_r;
  assign out_rsp.last         = out_last_r;

endmodule

// ----- design/llt_checker.sv -----
// Port-level checker for the linked-list table, bound to the top level.
// Depends on llt_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module llt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input llt_pkg::req_t  in_req_type,
  input logic           out_valid,
  input logic           out_ready,
  input llt_pkg::stat_t out_status,
  input llt_pkg::idx_t  out_new_head,
  input llt_pkg::idx_t  out_entry_index,
  input llt_pkg::khi_t  out_key_high,
  input llt_pkg::klo_t  out_key_low,
  input logic           out_last
);

  logic in_beat;
  logic out_stall;
  logic known_req;

  assign in_beat   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign known_req = (in_req_type == llt_pkg::REQ_ADD) ||
                     (in_req_type == llt_pkg::REQ_DELETE) ||
                     (in_req_type == llt_pkg::REQ_SEARCH);

  // A known request keeps the block busy in the following cycle.
  `LLT_ASSERT_NEXT(busy_after_req, clk, rst_n, in_beat && known_req, !in_ready)

  // Only search produces beats that are not the last of a request; they are ok.
  `LLT_ASSERT_SAME(mid_beat_ok, clk, rst_n, out_valid && !out_last,
                   out_status == llt_pkg::ST_OK)

  // An empty-list answer carries no head and no entry and ends the request.
  `LLT_ASSERT_SAME(empty_fields, clk, rst_n, out_valid && (out_status == llt_pkg::ST_EMPTY),
                   (out_new_head == llt_pkg::NO_ENTRY) &&
                   (out_entry_index == llt_pkg::NO_ENTRY) && out_last)

  // A stalled result beat stays valid and unchanged.
  `LLT_ASSERT_NEXT(stall_hold, clk, rst_n, out_stall,
                   out_valid && $stable(out_status) && $stable(out_new_head) &&
                   $stable(out_entry_index) && $stable(out_key_high) &&
                   $stable(out_key_low) && $stable(out_last))

endmodule

bind linked_list_table_with_free_list_unit llt_checker u_llt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .in_req_type     (in_req.req_type),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_status      (out_rsp.status),
  .out_new_head    (out_rsp.new_head),
  .out_entry_index (out_rsp.entry_index),
  .out_key_high    (out_rsp.out_key_high),
  .out_key_low     (out_rsp.out_key_low),
  .out_last        (out_rsp.last)
);

// ----- sim/linked_list_table_with_free_list_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the linked-list table with free list: random and directed
// add, delete and search requests against an in-bench model of the table.
// Depends on llt_pkg, llt_req_if, llt_rsp_if and linked_list_table_with_free_list_unit.
module linked_list_table_with_free_list_unit_tb;

  localparam int DEPTH       = 64;
  localparam int KEY_BYTES   = 15;
  localparam int LISTS       = 4;
  localparam int END_OF_LIST = -1;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam llt_pkg::req_t REQ_UNKNOWN = 2'd3;
  localparam llt_pkg::key_t KEY_MASK = {120{1'b1}} << (8 * (15 - KEY_BYTES));

  // One request beat, plus the list slot it was generated for (-1 for none).
  typedef struct {
    llt_pkg::req_t req;
    llt_pkg::idx_t head;
    llt_pkg::khi_t khi;
    llt_pkg::klo_t klo;
    int            slot;
  } list_req_t;

  // One result beat as the table should produce it.
  typedef struct {
    llt_pkg::stat_t status;
    llt_pkg::idx_t  new_head;
    llt_pkg::idx_t  entry_index;
    llt_pkg::khi_t  khi;
    llt_pkg::klo_t  klo;
    logic           last;
  } table_answer_t;

  logic clk;
  logic rst_n;

  llt_req_if req_bus();
  llt_rsp_if rsp_bus();

  linked_list_table_with_free_list_unit #(
    .TABLE_DEPTH(DEPTH),
    .KEY_BYTES  (KEY_BYTES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_bus),
    .out_rsp(rsp_bus)
  );

  // Model of the table contents.
  llt_pkg::key_t key_tbl [0:DEPTH-1];
  int   link_tbl[0:DEPTH-1];
  int   free_top;
  int   used_cnt;

  // Heads of the lists that the generator keeps track of.
  int   list_head[0:LISTS-1];
  llt_pkg::key_t key_pool[0:7];

  list_req_t     request_q[$];
  table_answer_t answer_q[$];
  event          req_taken_ev;

  bit quiet;
  bit req_done;
  int req_gap;
  int rsp_stall;
  int hold_cnt;
  int next_hold_at;
  int cycle_cnt;
  int bad_beats;
  int items_taken;
  int rsp_beats;
  int n_full, n_not_found, n_empty;
  int walk_len, longest_walk;

  function automatic int idx_to_int(llt_pkg::idx_t x);
    return int'($signed(x));
  endfunction

  function automatic bit live(int i);
    return i >= 0 && i < used_cnt && i < DEPTH;
  endfunction

  function automatic int norm(int i);
    return live(i) ? i : END_OF_LIST;
  endfunction

  function automatic void add_answer(llt_pkg::stat_t s, int nh, int ei, llt_pkg::key_t k,
                                     logic lst);
    table_answer_t a;
    a.status      = s;
    a.new_head    = llt_pkg::idx_t'(nh);
    a.entry_index = llt_pkg::idx_t'(ei);
    a.khi         = k[119:64];
    a.klo         = k[63:0];
    a.last        = lst;
    answer_q = {answer_q, a};
  endfunction

  // Applies one request to the table model and queues the answers it causes.
  function automatic void table_apply(list_req_t r);
    int   hd, e, cur, prv, n, tgt, aft, nx, cnt;
    llt_pkg::key_t k;
    hd = norm(idx_to_int(r.head));
    k  = {r.khi, r.klo} & KEY_MASK;
    case (r.req)
      llt_pkg::REQ_ADD: begin
        e = END_OF_LIST;
        if (live(free_top)) begin
          e = free_top;
          free_top = norm(link_tbl[e]);
        end else if (used_cnt < DEPTH) begin
          e = used_cnt;
          used_cnt++;
        end
        if (e < 0) begin
          add_answer(llt_pkg::ST_FULL, hd, END_OF_LIST, '0, 1'b1);
        end else begin
          key_tbl[e]  = k;
          link_tbl[e] = END_OF_LIST;
          prv = END_OF_LIST;
          cur = hd;
          // The walk is bounded, so a cyclic list still ends.
          for (n = 0; n < DEPTH && live(cur); n++) begin
            prv = cur;
            cur = link_tbl[cur];
          end
          if (live(prv)) begin
            link_tbl[prv] = e;
            add_answer(llt_pkg::ST_OK, hd, e, '0, 1'b1);
          end else begin
            add_answer(llt_pkg::ST_OK, e, e, '0, 1'b1);
          end
        end
      end
      llt_pkg::REQ_DELETE: begin
        tgt = END_OF_LIST;
        prv = END_OF_LIST;
        cur = hd;
        for (n = 0; n < DEPTH && live(cur) && tgt < 0; n++) begin
          if (key_tbl[cur] == k) tgt = cur;
          else begin
            prv = cur;
            cur = link_tbl[cur];
          end
        end
        if (tgt < 0) begin
          add_answer(llt_pkg::ST_NOT_FOUND, hd, END_OF_LIST, '0, 1'b1);
        end else begin
          aft = norm(link_tbl[tgt]);
          if (live(prv)) link_tbl[prv] = aft;
          link_tbl[tgt] = free_top;
          free_top = tgt;
          add_answer(llt_pkg::ST_OK, live(prv) ? hd : aft, tgt, '0, 1'b1);
        end
      end
      llt_pkg::REQ_SEARCH: begin
        if (!live(hd)) begin
          add_answer(llt_pkg::ST_EMPTY, END_OF_LIST, END_OF_LIST, '0, 1'b1);
        end else begin
          cur = hd;
          cnt = 0;
          while (cnt < DEPTH && live(cur)) begin
            nx = link_tbl[cur];
            add_answer(llt_pkg::ST_OK, hd, cur, key_tbl[cur],
                       (cnt + 1 >= DEPTH) || !live(nx));
            cnt++;
            cur = nx;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Picks a random entry along a list, or -1 if the list is empty.
  function automatic int pick_entry(int hd);
    int cur, cnt, pos;
    cur = hd;
    cnt = 0;
    while (cnt < DEPTH && live(cur)) begin
      cnt++;
      cur = link_tbl[cur];
    end
    if (cnt == 0) return END_OF_LIST;
    pos = $urandom_range(0, cnt - 1);
    cur = hd;
    repeat (pos) cur = link_tbl[cur];
    return cur;
  endfunction

  // Random key: pool keys give duplicates, extremes show up now and then.
  function automatic llt_pkg::key_t rand_key();
    logic [127:0] raw;
    int           pick;
    raw  = {$urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 3) return key_pool[$urandom_range(0, 7)];
    if (pick == 3) return '0;
    if (pick == 4) return '1;
    return raw[119:0];
  endfunction

  function automatic void check_field(string name, logic [119:0] want_v, logic [119:0] got_v);
    if (want_v !== got_v) begin
      bad_beats++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endfunction

  // Queues one request and waits until the table has taken it.
  task automatic send(llt_pkg::req_t rq, int hd, llt_pkg::key_t k, int slot);
    list_req_t r;
    r.req  = rq;
    r.head = llt_pkg::idx_t'(hd);
    r.khi  = k[119:64];
    r.klo  = k[63:0];
    r.slot = slot;
    request_q = {request_q, r};
    @(req_taken_ev);
  endtask

  task automatic wait_drained();
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic on the tracked lists, the rest noise that
  // corrupts lists, adds from a middle entry or uses arbitrary heads.
  task automatic send_random(int p_add, int p_del);
    int   slot, roll, e, hd;
    llt_pkg::key_t k;
    slot = $urandom_range(0, LISTS - 1);
    roll = $urandom_range(0, 99);
    k    = rand_key();
    if (roll < p_add) begin
      send(llt_pkg::REQ_ADD, list_head[slot], k, slot);
    end else if (roll < p_add + p_del) begin
      e = pick_entry(list_head[slot]);
      if (e >= 0 && $urandom_range(0, 4) != 0) k = key_tbl[e];
      send(llt_pkg::REQ_DELETE, list_head[slot], k, slot);
    end else if (roll < p_add + p_del + 15) begin
      send(llt_pkg::REQ_SEARCH, list_head[slot], k, slot);
    end else begin
      e = pick_entry(list_head[slot]);
      case ($urandom_range(0, 2))
        0: begin
          // Deleting from the middle leaves the predecessor pointing at a free entry.
          if (e >= 0) send(llt_pkg::REQ_DELETE, e, key_tbl[e], -1);
          else send(llt_pkg::REQ_SEARCH, END_OF_LIST, k, -1);
        end
        1: begin
          hd = int'($urandom_range(0, 64)) - 1;
          send(llt_pkg::req_t'($urandom_range(0, 2)), hd, k, -1);
        end
        default: send(llt_pkg::REQ_ADD, e, k, -1);
      endcase
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timeout guard.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  // Request driver: holds a beat until taken, then idles for the drawn gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_done) begin
      req_done = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
        req_bus.valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        req_bus.req_type <= request_q[0].req;
        req_bus.head     <= request_q[0].head;
        req_bus.key_high <= request_q[0].khi;
        req_bus.key_low  <= request_q[0].klo;
        req_bus.valid    <= 1'b1;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Request beat taken: update the model and the tracked list heads.
  always @(posedge clk) begin : take_req
    list_req_t r;
    if (rst_n && req_bus.valid && req_bus.ready) begin
      r = request_q.pop_front();
      table_apply(r);
      if (r.slot >= 0 && (r.req == llt_pkg::REQ_ADD || r.req == llt_pkg::REQ_DELETE))
        list_head[r.slot] = idx_to_int(answer_q[$].new_head);
      items_taken++;
      req_done = 1'b1;
      req_gap  = quiet ? 0 : $urandom_range(0, 11);
      -> req_taken_ev;
    end
  end

  // Result receiver: short stalls after each beat, long hold-offs now and then.
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (hold_cnt == 0 && rsp_beats >= next_hold_at) begin
        hold_cnt = HOLD_CYCLES;
        next_hold_at += 700;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_bus.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Result monitor: compares each beat with the oldest expected answer.
  always @(posedge clk) begin : watch_rsp
    table_answer_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      rsp_stall = quiet ? 0 : $urandom_range(0, 11);
      rsp_beats++;
      if (answer_q.size() == 0) begin
        bad_beats++;
        $display("%0t: result beat with nothing expected, status %0d entry %0h",
                 $time, rsp_bus.status, rsp_bus.entry_index);
      end else begin
        want = answer_q.pop_front();
        check_field("status", want.status, rsp_bus.status);
        check_field("new_head", want.new_head, rsp_bus.new_head);
        check_field("entry_index", want.entry_index, rsp_bus.entry_index);
        check_field("out_key_high", want.khi, rsp_bus.out_key_high);
        check_field("out_key_low", want.klo, rsp_bus.out_key_low);
        check_field("last", want.last, rsp_bus.last);
        if (want.status == llt_pkg::ST_FULL) n_full++;
        if (want.status == llt_pkg::ST_NOT_FOUND) n_not_found++;
        if (want.status == llt_pkg::ST_EMPTY) n_empty++;
        walk_len++;
        if (want.last) begin
          if (walk_len > longest_walk) longest_walk = walk_len;
          walk_len = 0;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    logic [127:0] raw;
    llt_pkg::key_t k_alt_a, k_alt_b, k_miss;
    int           i, s;

    rst_n            = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = llt_pkg::REQ_ADD;
    req_bus.head     = '0;
    req_bus.key_high = '0;
    req_bus.key_low  = '0;
    rsp_bus.ready    = 1'b0;
    quiet        = 1'b0;
    req_done     = 1'b0;
    req_gap      = 0;
    rsp_stall    = 0;
    hold_cnt     = 0;
    next_hold_at = 150;
    bad_beats    = 0;
    items_taken  = 0;
    rsp_beats    = 0;
    n_full       = 0;
    n_not_found  = 0;
    n_empty      = 0;
    walk_len     = 0;
    longest_walk = 0;
    free_top     = END_OF_LIST;
    used_cnt     = 0;
    for (i = 0; i < DEPTH; i++) begin
      key_tbl[i]  = '0;
      link_tbl[i] = 0;
    end
    for (i = 0; i < LISTS; i++) list_head[i] = END_OF_LIST;
    for (i = 0; i < 8; i++) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      key_pool[i] = raw[119:0];
    end
    k_alt_a = {60{2'b10}};
    k_alt_b = {60{2'b01}};
    k_miss  = 120'h123;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty list cases, an ignored code, then build and take apart a list.
    send(llt_pkg::REQ_SEARCH, list_head[0], '0, 0);
    send(llt_pkg::REQ_DELETE, list_head[0], '1, 0);
    send(REQ_UNKNOWN, END_OF_LIST, '0, -1);
    send(llt_pkg::REQ_ADD, list_head[0], '0, 0);
    send(llt_pkg::REQ_ADD, list_head[0], '1, 0);
    send(llt_pkg::REQ_ADD, list_head[0], k_alt_a, 0);
    send(llt_pkg::REQ_ADD, list_head[0], k_alt_b, 0);
    send(llt_pkg::REQ_SEARCH, list_head[0], '0, 0);
    send(llt_pkg::REQ_DELETE, list_head[0], k_miss, 0);
    send(llt_pkg::REQ_DELETE, list_head[0], k_alt_a, 0);
    send(llt_pkg::REQ_DELETE, list_head[0], '0, 0);
    send(llt_pkg::REQ_DELETE, list_head[0], k_alt_b, 0);
    // Freed entries come back from the free list; duplicate keys delete the first.
    send(llt_pkg::REQ_ADD, list_head[1], '1, 1);
    send(llt_pkg::REQ_ADD, list_head[1], '1, 1);
    send(llt_pkg::REQ_DELETE, list_head[1], '1, 1);
    send(llt_pkg::REQ_SEARCH, list_head[1], '0, 1);
    send(llt_pkg::REQ_SEARCH, list_head[0], '0, 0);
    // A head beyond the used entries counts as an empty list.
    send(llt_pkg::REQ_SEARCH, 63, '1, -1);
    send(llt_pkg::REQ_ADD, 63, k_alt_b, -1);
    send(llt_pkg::REQ_SEARCH, END_OF_LIST, '1, -1);
    wait_drained();

    // Growth phase with a stretch of back-to-back traffic.
    for (i = 0; i < 120; i++) begin
      quiet = (i >= 40 && i < 70);
      send_random(55, 20);
    end
    quiet = 1'b0;

    // Fill the table, then ask for more entries than it holds.
    while (!(used_cnt == DEPTH && !live(free_top))) begin
      s = $urandom_range(0, LISTS - 1);
      send(llt_pkg::REQ_ADD, list_head[s], rand_key(), s);
    end
    for (i = 0; i < 3; i++) begin
      s = $urandom_range(0, LISTS - 1);
      send(llt_pkg::REQ_ADD, list_head[s], rand_key(), s);
    end
    for (i = 0; i < LISTS; i++) send(llt_pkg::REQ_SEARCH, list_head[i], '0, i);
    wait_drained();

    // Drain phase, then a mixed phase that starts without idling.
    for (i = 0; i < 120; i++) send_random(25, 45);
    for (i = 0; i < 110; i++) begin
      quiet = (i < 40);
      send_random(40, 35);
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests and checked %0d result beats; longest answer %0d beats.",
             items_taken, rsp_beats, longest_walk);
    $display("Answers seen: %0d table full, %0d key not found, %0d empty list.",
             n_full, n_not_found, n_empty);
    if (bad_beats == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
